// File: sv/tss_pkg.sv
// Shared types, constants and saturation helpers for the tridiagonal solver.
// No dependencies; every other file of the block imports this package.
package tss_pkg;

   localparam int MAX_ROWS_DEF  = 64;
   localparam int FRAC_BITS_DEF = 16;
   localparam int DATA_W        = 32;
   localparam int ROW_W         = 6;
   localparam int QUOT_W        = 33;
   localparam int QUEUE_DEPTH   = 2;

   localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef struct packed {
      logic signed [DATA_W-1:0] lower_diag;
      logic signed [DATA_W-1:0] main_diag;
      logic signed [DATA_W-1:0] super_diag;
      logic signed [DATA_W-1:0] rhs_value;
      logic                     last_row;
   } req_type;

   typedef struct packed {
      logic [ROW_W-1:0]         row_index;
      logic signed [DATA_W-1:0] solution;
      logic                     div_error;
      logic                     last_result;
   } rsp_type;

   typedef struct packed {
      req_type          row;
      logic             first;
      logic             last;
      logic [ROW_W-1:0] idx;
   } row_item_type;

   typedef struct packed {
      logic                     start;
      logic signed [DATA_W-1:0] numer;
      logic signed [DATA_W-1:0] denom;
   } div_req_type;

   typedef struct packed {
      logic                     busy;
      logic                     done;
      logic signed [DATA_W-1:0] quot;
   } div_rsp_type;

   function automatic logic signed [DATA_W-1:0] sat_wide(input logic signed [63:0] v);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      begin
         hi = 64'(DATA_MAX);
         lo = 64'(DATA_MIN);
         if (v > hi) begin
            sat_wide = DATA_MAX;
         end else if (v < lo) begin
            sat_wide = DATA_MIN;
         end else begin
            sat_wide = v[DATA_W-1:0];
         end
      end
   endfunction

   function automatic logic signed [DATA_W-1:0] sat_sub(input logic signed [DATA_W-1:0] a,
                                                        input logic signed [DATA_W-1:0] b);
      logic signed [DATA_W:0] d;
      begin
         d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
         if (d[DATA_W] != d[DATA_W-1]) begin
            sat_sub = d[DATA_W] ? DATA_MIN : DATA_MAX;
         end else begin
            sat_sub = d[DATA_W-1:0];
         end
      end
   endfunction

endpackage

// File: sv/tridiagonal_system_solver_core.sv
// Tridiagonal solver (Thomas algorithm) in signed fixed point, FRAC_BITS fraction bits in
// 32. Send one row per request; the row flagged last (or row MAX_ROWS-1) ends the system,
// and the solution then comes out from the highest row down to row 0, last_result on row 0.
// All rows share one iterative divider: row 0 needs no forward division, every later
// row waits for one quotient, and so does each solution element once the last row is in
// (sooner when a quotient saturates early or the divisor is zero).
// A two-entry queue lets the next rows arrive while the current one is worked on.
module tridiagonal_system_solver_core #(
   parameter int MAX_ROWS  = tss_pkg::MAX_ROWS_DEF,
   parameter int FRAC_BITS = tss_pkg::FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tss_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tss_pkg::rsp_type rsp_data
);
   import tss_pkg::*;

   logic         item_valid, item_pop;
   row_item_type item_data;
   div_req_type  div_req;
   div_rsp_type  div_rsp;

   tss_front #(.MAX_ROWS(MAX_ROWS)) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .item_valid(item_valid), .item_data(item_data), .item_pop(item_pop)
   );

   tss_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock(clock), .reset(reset), .div_req(div_req), .div_rsp(div_rsp)
   );

   tss_back #(.MAX_ROWS(MAX_ROWS), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock(clock), .reset(reset),
      .item_valid(item_valid), .item_data(item_data), .item_pop(item_pop),
      .div_req(div_req), .div_rsp(div_rsp),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

`ifndef SYNTHESIS
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");

   a_last_is_row0: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last_result) |-> (rsp_data.row_index == '0))
      else $error("last result not on row 0");

   a_pop_has_item: assert property (@(posedge clock) disable iff (reset)
      item_pop |-> item_valid)
      else $error("row queue popped while empty");
`endif

endmodule

// File: sv/tss_front.sv
// Front end of the solver: accepts rows, numbers them and marks first/last rows,
// then queues them for the back end. Depends on tss_pkg.
module tss_front #(
   parameter int MAX_ROWS = tss_pkg::MAX_ROWS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  tss_pkg::req_type      req_data,
   output logic                  item_valid,
   output tss_pkg::row_item_type item_data,
   input  logic                  item_pop
);
   import tss_pkg::*;

   localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

   logic [AW-1:0]  cnt_ff, cnt_in;
   row_item_type   queue_ff [QUEUE_DEPTH];
   logic           wptr_ff, wptr_in;
   logic           rptr_ff, rptr_in;
   logic [1:0]     fill_ff, fill_in;
   logic           push;
   row_item_type   new_item;

   assign req_ready  = (fill_ff != 2'(QUEUE_DEPTH));
   assign push       = req_valid && req_ready;
   assign item_valid = (fill_ff != 2'd0);
   assign item_data  = queue_ff[rptr_ff];

   always_comb begin
      new_item.row   = req_data;
      new_item.first = (cnt_ff == '0);
      // A row that lands in the last slot closes the system regardless of the flag.
      new_item.last  = req_data.last_row || (cnt_ff == AW'(MAX_ROWS - 1));
      new_item.idx   = ROW_W'(cnt_ff);
      cnt_in  = cnt_ff;
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      fill_in = fill_ff;
      if (push) begin
         cnt_in  = new_item.last ? '0 : cnt_ff + 1'b1;
         wptr_in = ~wptr_ff;
      end
      if (item_pop && item_valid) begin
         rptr_in = ~rptr_ff;
      end
      fill_in = fill_ff + 2'(push) - 2'(item_pop && item_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         cnt_ff  <= cnt_in;
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wptr_ff] <= new_item;
      end
   end

endmodule

// File: sv/tss_div.sv
// Radix-2 restoring divider for (n * 2^FRAC_BITS) / d with saturation.
// Depends on tss_pkg. A request that saturates early or has a zero divisor finishes without iterating.
module tss_div #(
   parameter int FRAC_BITS = tss_pkg::FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tss_pkg::div_req_type div_req,
   output tss_pkg::div_rsp_type div_rsp
);
   import tss_pkg::*;

   localparam int W  = DATA_W + FRAC_BITS;
   localparam int UW = W - QUOT_W;
   localparam int CW = $clog2(QUOT_W + 1);

   logic              busy_ff, busy_in;
   logic              fin_ff, fin_in;
   logic              done_ff, done_in;
   logic              neg_ff, neg_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] dmag_ff, dmag_in;
   logic [QUOT_W-1:0] dvd_ff, dvd_in;
   logic signed [DATA_W-1:0] quot_ff, quot_in;

   logic [DATA_W-1:0] nabs, dabs;
   logic [W-1:0]      nmag;
   logic [UW-1:0]     upper;
   logic [DATA_W:0]   trial;
   logic              ge;

   always_comb begin
      nabs  = div_req.numer[DATA_W-1] ? (~div_req.numer + 1'b1) : div_req.numer;
      dabs  = div_req.denom[DATA_W-1] ? (~div_req.denom + 1'b1) : div_req.denom;
      nmag  = {nabs, {FRAC_BITS{1'b0}}};
      upper = nmag[W-1:QUOT_W];
      trial = {rem_ff, dvd_ff[QUOT_W-1]};
      ge    = (trial >= {1'b0, dmag_ff});

      busy_in = busy_ff;
      fin_in  = 1'b0;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dmag_in = dmag_ff;
      dvd_in  = dvd_ff;
      quot_in = quot_ff;

      if (div_req.start) begin
         neg_in  = div_req.numer[DATA_W-1] ^ div_req.denom[DATA_W-1];
         dmag_in = dabs;
         if (div_req.denom == '0) begin
            quot_in = div_req.numer[DATA_W-1] ? DATA_MIN : DATA_MAX;
            done_in = 1'b1;
         end else if ({{(DATA_W-UW){1'b0}}, upper} >= dabs) begin
            // The quotient needs more than QUOT_W bits, so it saturates.
            quot_in = (div_req.numer[DATA_W-1] ^ div_req.denom[DATA_W-1]) ? DATA_MIN
                                                                           : DATA_MAX;
            done_in = 1'b1;
         end else begin
            rem_in  = {{(DATA_W-UW){1'b0}}, upper};
            dvd_in  = nmag[QUOT_W-1:0];
            cnt_in  = CW'(QUOT_W);
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in = ge ? DATA_W'(trial - {1'b0, dmag_ff}) : trial[DATA_W-1:0];
         dvd_in = {dvd_ff[QUOT_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end else if (fin_ff) begin
         done_in = 1'b1;
         if (neg_ff) begin
            quot_in = (dvd_ff > {2'b01, {(QUOT_W-2){1'b0}}}) ? DATA_MIN
                                                            : DATA_W'(~dvd_ff + 1'b1);
         end else begin
            quot_in = (dvd_ff[QUOT_W-1] || dvd_ff[QUOT_W-2]) ? DATA_MAX
                                                             : dvd_ff[DATA_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      dmag_ff <= dmag_in;
      dvd_ff  <= dvd_in;
      quot_ff <= quot_in;
   end

   assign div_rsp.busy = busy_ff || fin_ff;
   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

endmodule

// File: sv/tss_back.sv
// Back end of the solver: forward elimination per row, then back substitution.
// Holds the row memories and the output register. Depends on tss_pkg; talks to tss_div through its ports.
module tss_back #(
   parameter int MAX_ROWS  = tss_pkg::MAX_ROWS_DEF,
   parameter int FRAC_BITS = tss_pkg::FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  tss_pkg::row_item_type item_data,
   output logic                  item_pop,
   output tss_pkg::div_req_type  div_req,
   input  tss_pkg::div_rsp_type  div_rsp,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output tss_pkg::rsp_type      rsp_data
);
   import tss_pkg::*;

   localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b00000000001,
      ST_FSTART = 11'b00000000010,
      ST_FDIV   = 11'b00000000100,
      ST_FMUL   = 11'b00000001000,
      ST_FSUB1  = 11'b00000010000,
      ST_FSUB2  = 11'b00000100000,
      ST_STORE  = 11'b00001000000,
      ST_BDIV   = 11'b00010000000,
      ST_EMIT   = 11'b00100000000,
      ST_BREAD  = 11'b01000000000,
      ST_BSUB   = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   row_item_type item_ff, item_in;
   logic signed [DATA_W-1:0] m_ff, m_in;
   logic signed [63:0]       prod_ff, prod_in;
   logic signed [DATA_W-1:0] piv_cur_ff, piv_cur_in, rhs_cur_ff, rhs_cur_in;
   logic signed [DATA_W-1:0] prev_piv_ff, prev_piv_in, prev_rhs_ff, prev_rhs_in;
   logic signed [DATA_W-1:0] prev_up_ff, prev_up_in, x_ff, x_in;
   logic          fault_ff, fault_in, err_ff, err_in;
   logic [AW-1:0] bidx_ff, bidx_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   logic signed [DATA_W-1:0] piv_mem [MAX_ROWS];
   logic signed [DATA_W-1:0] rhs_mem [MAX_ROWS];
   logic signed [DATA_W-1:0] up_mem  [MAX_ROWS];
   logic signed [DATA_W-1:0] piv_rd_ff, rhs_rd_ff, up_rd_ff;

   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic signed [DATA_W-1:0] mul_a, mul_b, scaled;
   logic signed [63:0]       prod_shift;
   logic          out_free;

   always_comb begin
      prod_shift = prod_ff >>> FRAC_BITS;
      scaled     = sat_wide(prod_shift);
      out_free   = !rsp_valid_ff || rsp_ready;

      state_in     = state_ff;
      item_in      = item_ff;
      m_in         = m_ff;
      prod_in      = prod_ff;
      piv_cur_in   = piv_cur_ff;
      rhs_cur_in   = rhs_cur_ff;
      prev_piv_in  = prev_piv_ff;
      prev_rhs_in  = prev_rhs_ff;
      prev_up_in   = prev_up_ff;
      x_in         = x_ff;
      fault_in     = fault_ff;
      err_in       = err_ff;
      bidx_in      = bidx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      item_pop     = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = item_ff.idx[AW-1:0];
      rd_en        = 1'b0;
      rd_addr      = bidx_ff - 1'b1;
      mul_a        = m_ff;
      mul_b        = prev_up_ff;
      div_req.start = 1'b0;
      div_req.numer = item_ff.row.lower_diag;
      div_req.denom = prev_piv_ff;

      case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               item_in  = item_data;
               state_in = ST_FSTART;
            end
         end
         ST_FSTART: begin
            if (item_ff.first) begin
               piv_cur_in = item_ff.row.main_diag;
               rhs_cur_in = item_ff.row.rhs_value;
               state_in   = ST_STORE;
            end else begin
               div_req.start = 1'b1;
               if (prev_piv_ff == '0) begin
                  fault_in = 1'b1;
               end
               state_in = ST_FDIV;
            end
         end
         ST_FDIV: begin
            if (div_rsp.done) begin
               m_in     = div_rsp.quot;
               state_in = ST_FMUL;
            end
         end
         ST_FMUL: begin
            prod_in  = 64'(mul_a) * 64'(mul_b);
            state_in = ST_FSUB1;
         end
         ST_FSUB1: begin
            piv_cur_in = sat_sub(item_ff.row.main_diag, scaled);
            mul_b      = prev_rhs_ff;
            prod_in    = 64'(mul_a) * 64'(mul_b);
            state_in   = ST_FSUB2;
         end
         ST_FSUB2: begin
            rhs_cur_in = sat_sub(item_ff.row.rhs_value, scaled);
            state_in   = ST_STORE;
         end
         ST_STORE: begin
            wr_en       = 1'b1;
            prev_piv_in = piv_cur_ff;
            prev_rhs_in = rhs_cur_ff;
            prev_up_in  = item_ff.row.super_diag;
            if (item_ff.last) begin
               err_in        = fault_ff || (piv_cur_ff == '0);
               div_req.start = 1'b1;
               div_req.numer = rhs_cur_ff;
               div_req.denom = piv_cur_ff;
               bidx_in       = item_ff.idx[AW-1:0];
               state_in      = ST_BDIV;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_BDIV: begin
            if (div_rsp.done) begin
               x_in     = div_rsp.quot;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.row_index   = ROW_W'(bidx_ff);
               rsp_data_in.solution    = x_ff;
               rsp_data_in.div_error   = err_ff;
               rsp_data_in.last_result = (bidx_ff == '0);
               if (bidx_ff == '0) begin
                  fault_in = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  rd_en    = 1'b1;
                  bidx_in  = bidx_ff - 1'b1;
                  state_in = ST_BREAD;
               end
            end
         end
         ST_BREAD: begin
            mul_a    = up_rd_ff;
            mul_b    = x_ff;
            prod_in  = 64'(mul_a) * 64'(mul_b);
            state_in = ST_BSUB;
         end
         ST_BSUB: begin
            div_req.start = 1'b1;
            div_req.numer = sat_sub(rhs_rd_ff, scaled);
            div_req.denom = piv_rd_ff;
            state_in      = ST_BDIV;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fault_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fault_ff     <= fault_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      m_ff        <= m_in;
      prod_ff     <= prod_in;
      piv_cur_ff  <= piv_cur_in;
      rhs_cur_ff  <= rhs_cur_in;
      prev_piv_ff <= prev_piv_in;
      prev_rhs_ff <= prev_rhs_in;
      prev_up_ff  <= prev_up_in;
      x_ff        <= x_in;
      err_ff      <= err_in;
      bidx_ff     <= bidx_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         piv_mem[wr_addr] <= piv_cur_ff;
         rhs_mem[wr_addr] <= rhs_cur_ff;
         up_mem[wr_addr]  <= item_ff.row.super_diag;
      end
      if (rd_en) begin
         piv_rd_ff <= piv_mem[rd_addr];
         rhs_rd_ff <= rhs_mem[rd_addr];
         up_rd_ff  <= up_mem[rd_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
